// File: src/tcpq_pkg.sv
// Package for the two-class priority queue: sizes, request and status codes,
// controller state and command types, ring pointer helper.
// No dependencies.
`timescale 1ns / 1ps

package tcpq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int TOT_W       = CNT_W + 1;
    localparam int VALUE_W     = 32;
    localparam int ENTRY_W     = 5;

    typedef enum logic [1:0] {
        REQ_ENQUEUE = 2'd0,
        REQ_DEQUEUE = 2'd1,
        REQ_PROMOTE = 2'd2,
        REQ_UNUSED  = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_FULL      = 2'd1,
        STAT_EMPTY     = 2'd2,
        STAT_NO_NORMAL = 2'd3
    } status_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } state_t;

    typedef struct packed {
        logic load;
        logic commit;
    } dp_cmd_t;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
            r = '0;
        end else begin
            r = p + 1'b1;
        end
        return r;
    endfunction

endpackage

// File: src/two_class_priority_queue_core.sv
// Top level of the two-class priority queue: stream ports around the
// controller and datapath. Depends on tcpq_pkg, tcpq_ctrl, tcpq_datapath.
//
//   channel | dir | tdata                         | tuser
//   s_      | in  | [31:0] item_value             | [1:0] req_type, [2] is_urgent
//   m_      | out | [31:0] out_value, [36:32] cnt | [1:0] status
//
// Each request is accepted in ST_IDLE and then executed in ST_EXEC against the
// registered RAM head reads, which loads the result register.
// The next request is accepted while a result beat waits; execution stalls
// only when the result register is still full. Reset is synchronous and
// empties both rings at once; no clearing pass.
`timescale 1ns / 1ps

module two_class_priority_queue_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] item_value
    input  logic [2:0]  s_tuser,   // [1:0] req_type, [2] is_urgent
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [31:0] out_value, [36:32] entry_count, [39:37] zero
    output logic [1:0]  m_tuser    // [1:0] status
);

    tcpq_pkg::dp_cmd_t                    cmd;
    logic signed [tcpq_pkg::VALUE_W-1:0]  out_value;
    logic [1:0]                           out_status;
    logic [tcpq_pkg::ENTRY_W-1:0]         out_entry_count;

    tcpq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    tcpq_datapath u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .in_req          (s_tuser[1:0]),
        .in_value        (s_tdata),
        .in_urgent       (s_tuser[2]),
        .out_value       (out_value),
        .out_status      (out_status),
        .out_entry_count (out_entry_count)
    );

    assign m_tdata = {3'b000, out_entry_count, out_value};
    assign m_tuser = out_status;

endmodule

// File: src/tcpq_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module tcpq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// File: src/tcpq_ctrl.sv
// Controller for the two-class priority queue: accept, execute, result handoff.
// Depends on tcpq_pkg.
`timescale 1ns / 1ps

module tcpq_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    output logic             m_tvalid,
    input  logic             m_tready,
    output tcpq_pkg::dp_cmd_t cmd
);

    tcpq_pkg::state_t state_reg, state_next;
    logic             m_tvalid_reg, m_tvalid_next;
    logic             out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= tcpq_pkg::ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        state_next    = state_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        s_tready      = 1'b0;
        cmd           = '0;
        unique case (state_reg)
            tcpq_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = tcpq_pkg::ST_EXEC;
                end
            end
            tcpq_pkg::ST_EXEC: begin
                if (out_free) begin
                    cmd.commit    = 1'b1;
                    m_tvalid_next = 1'b1;
                    state_next    = tcpq_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = tcpq_pkg::ST_IDLE;
            end
        endcase
    end

    assign m_tvalid = m_tvalid_reg;

`ifndef NO_ASSERTIONS
    a_load_to_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |=> state_reg == tcpq_pkg::ST_EXEC)
        else $error("accepted beat did not move to execute");
    a_commit_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |=> m_tvalid_reg)
        else $error("committed request has no result beat");
    a_commit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |-> (!m_tvalid_reg || m_tready))
        else $error("result overwritten before taken");
`endif

endmodule

// File: src/tcpq_datapath.sv
// Datapath for the two-class priority queue: two ring FIFOs in RAM, pointers,
// counts and the result register. Depends on tcpq_pkg and tcpq_ram.
`timescale 1ns / 1ps

module tcpq_datapath (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  tcpq_pkg::dp_cmd_t                    cmd,
    input  logic [1:0]                           in_req,
    input  logic signed [tcpq_pkg::VALUE_W-1:0]  in_value,
    input  logic                                 in_urgent,
    output logic signed [tcpq_pkg::VALUE_W-1:0]  out_value,
    output logic [1:0]                           out_status,
    output logic [tcpq_pkg::ENTRY_W-1:0]         out_entry_count
);

    tcpq_pkg::req_t                       req_reg;
    logic signed [tcpq_pkg::VALUE_W-1:0]  value_reg;
    logic                                 urgent_reg;

    logic [tcpq_pkg::PTR_W-1:0] u_head_reg, u_head_next, u_tail_reg, u_tail_next;
    logic [tcpq_pkg::PTR_W-1:0] n_head_reg, n_head_next, n_tail_reg, n_tail_next;
    logic [tcpq_pkg::CNT_W-1:0] u_cnt_reg, u_cnt_next, n_cnt_reg, n_cnt_next;

    logic signed [tcpq_pkg::VALUE_W-1:0]  out_value_reg, res_value;
    tcpq_pkg::status_t                    status_reg, res_status;
    logic [tcpq_pkg::ENTRY_W-1:0]         entry_reg;

    logic [tcpq_pkg::TOT_W-1:0]                  total, total_next;
    logic [tcpq_pkg::ENTRY_W+tcpq_pkg::TOT_W-1:0] total_wide;
    logic                                        full;

    logic                         u_wr, n_wr;
    logic [tcpq_pkg::VALUE_W-1:0] u_wr_data, u_rd_data, n_rd_data;

    tcpq_ram #(.WIDTH(tcpq_pkg::VALUE_W), .DEPTH(tcpq_pkg::QUEUE_DEPTH)) u_urgent_ram (
        .aclk    (aclk),
        .wr_en   (u_wr),
        .wr_addr (u_tail_reg),
        .wr_data (u_wr_data),
        .rd_addr (u_head_reg),
        .rd_data (u_rd_data)
    );

    tcpq_ram #(.WIDTH(tcpq_pkg::VALUE_W), .DEPTH(tcpq_pkg::QUEUE_DEPTH)) u_normal_ram (
        .aclk    (aclk),
        .wr_en   (n_wr),
        .wr_addr (n_tail_reg),
        .wr_data (value_reg),
        .rd_addr (n_head_reg),
        .rd_data (n_rd_data)
    );

    assign total      = {1'b0, u_cnt_reg} + {1'b0, n_cnt_reg};
    assign total_next = {1'b0, u_cnt_next} + {1'b0, n_cnt_next};
    assign total_wide = {{tcpq_pkg::ENTRY_W{1'b0}}, total_next};
    assign full       = total >= tcpq_pkg::TOT_W'(tcpq_pkg::QUEUE_DEPTH);

    always_comb begin
        u_head_next = u_head_reg;
        u_tail_next = u_tail_reg;
        n_head_next = n_head_reg;
        n_tail_next = n_tail_reg;
        u_cnt_next  = u_cnt_reg;
        n_cnt_next  = n_cnt_reg;
        u_wr        = 1'b0;
        n_wr        = 1'b0;
        u_wr_data   = value_reg;
        res_value   = '0;
        res_status  = tcpq_pkg::STAT_OK;
        unique case (req_reg)
            tcpq_pkg::REQ_ENQUEUE: begin
                if (full) begin
                    res_status = tcpq_pkg::STAT_FULL;
                end else if (urgent_reg) begin
                    u_wr        = 1'b1;
                    u_tail_next = tcpq_pkg::ptr_inc(u_tail_reg);
                    u_cnt_next  = u_cnt_reg + 1'b1;
                end else begin
                    n_wr        = 1'b1;
                    n_tail_next = tcpq_pkg::ptr_inc(n_tail_reg);
                    n_cnt_next  = n_cnt_reg + 1'b1;
                end
            end
            tcpq_pkg::REQ_DEQUEUE: begin
                if (u_cnt_reg != '0) begin
                    res_value   = u_rd_data;
                    u_head_next = tcpq_pkg::ptr_inc(u_head_reg);
                    u_cnt_next  = u_cnt_reg - 1'b1;
                end else if (n_cnt_reg != '0) begin
                    res_value   = n_rd_data;
                    n_head_next = tcpq_pkg::ptr_inc(n_head_reg);
                    n_cnt_next  = n_cnt_reg - 1'b1;
                end else begin
                    res_status = tcpq_pkg::STAT_EMPTY;
                end
            end
            tcpq_pkg::REQ_PROMOTE: begin
                if (n_cnt_reg != '0) begin
                    u_wr        = 1'b1;
                    u_wr_data   = n_rd_data;
                    u_tail_next = tcpq_pkg::ptr_inc(u_tail_reg);
                    u_cnt_next  = u_cnt_reg + 1'b1;
                    n_head_next = tcpq_pkg::ptr_inc(n_head_reg);
                    n_cnt_next  = n_cnt_reg - 1'b1;
                end else begin
                    res_status = tcpq_pkg::STAT_NO_NORMAL;
                end
            end
            tcpq_pkg::REQ_UNUSED: begin
                res_status = tcpq_pkg::STAT_OK;
            end
            default: begin
                res_status = tcpq_pkg::STAT_OK;
            end
        endcase
        u_wr = u_wr && cmd.commit;
        n_wr = n_wr && cmd.commit;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            u_head_reg <= '0;
            u_tail_reg <= '0;
            n_head_reg <= '0;
            n_tail_reg <= '0;
            u_cnt_reg  <= '0;
            n_cnt_reg  <= '0;
        end else if (cmd.commit) begin
            u_head_reg <= u_head_next;
            u_tail_reg <= u_tail_next;
            n_head_reg <= n_head_next;
            n_tail_reg <= n_tail_next;
            u_cnt_reg  <= u_cnt_next;
            n_cnt_reg  <= n_cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            req_reg    <= tcpq_pkg::req_t'(in_req);
            value_reg  <= in_value;
            urgent_reg <= in_urgent;
        end
        if (cmd.commit) begin
            out_value_reg <= res_value;
            status_reg    <= res_status;
            entry_reg     <= total_wide[tcpq_pkg::ENTRY_W-1:0];
        end
    end

    assign out_value       = out_value_reg;
    assign out_status      = status_reg;
    assign out_entry_count = entry_reg;

`ifndef NO_ASSERTIONS
    a_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        total <= tcpq_pkg::TOT_W'(tcpq_pkg::QUEUE_DEPTH))
        else $error("entries exceed queue depth");
    a_promote_keeps: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit && req_reg == tcpq_pkg::REQ_PROMOTE |=> total == $past(total))
        else $error("promote changed the entry total");
    a_deq_drops: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit && req_reg == tcpq_pkg::REQ_DEQUEUE && total != '0
        |=> total == $past(total) - 1'b1)
        else $error("dequeue did not remove one entry");
    a_idle_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !cmd.commit |=> $stable(u_head_reg) && $stable(n_head_reg) && $stable(total))
        else $error("queue state moved without a commit");
`endif

endmodule
